// ===== rtl/assert_macros.svh =====
// assertion helper macros for the syrk block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock unless reset is active
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

// ===== rtl/syrk_pkg.sv =====
// ----------------------------------------------------------------------------
// syrk_pkg
// types and codes shared by the symmetric rank-k update core and its checker
// ----------------------------------------------------------------------------
package syrk_pkg;

	localparam int unsigned STORE_DIM = 64;
	localparam int unsigned IDX_W = 6;

	typedef enum logic [1:0] {
		OP_WRITE_A = 2'd0,
		OP_WRITE_C = 2'd1,
		OP_RUN     = 2'd2,
		OP_READ_C  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_LOWER     = 3'd0,
		REG_TRANSPOSE = 3'd1,
		REG_SIZE_N    = 3'd2,
		REG_DEPTH_K   = 3'd3,
		REG_ALPHA     = 3'd4,
		REG_BETA      = 3'd5
	} reg_idx_t;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic [1:0]        operation;
		logic [5:0]        row_index;
		logic [5:0]        col_index;
		logic signed [31:0] element_value;
	} in_item_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] read_value;
	} out_item_t;

endpackage

// ===== rtl/symmetric_rank_k_update_core.sv =====
// ----------------------------------------------------------------------------
// symmetric_rank_k_update_core
// C = alpha*op(A)*op(A)^T + beta*C over one triangle, A and C in block memory
// ----------------------------------------------------------------------------
// write: stored at acceptance; read: rd_pend_q, then out_q and out_valid_q are registered
// throughput: one write per cycle while idle with no result waiting; no read is taken while
//   another is pending; a waiting result holds the input. run: each in-triangle entry uses
//   the single A read port and a limb-wise alpha multiply, others are skipped, then done
// reset: arst_n clears control and registers to their reset values;
//   A and C memories hold no defined content until written
module symmetric_rank_k_update_core #(
	parameter int unsigned MAX_N = 64,
	parameter int unsigned MAX_K = 64,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  syrk_pkg::in_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output syrk_pkg::out_item_t   out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	localparam int unsigned SW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
	localparam int unsigned LIM_N = (MAX_N < 64) ? MAX_N : 64;
	localparam int unsigned LIM_K = (MAX_K < 64) ? MAX_K : 64;
	localparam logic signed [63:0] MAXP = (64'sd1 <<< (SW - 1)) - 64'sd1;
	localparam logic signed [63:0] MINN = -(64'sd1 <<< (SW - 1));

	typedef enum logic [9:0] {
		ST_IDLE = 10'b0000000001,
		ST_RDC  = 10'b0000000010,
		ST_RDI  = 10'b0000000100,
		ST_RDJ  = 10'b0000001000,
		ST_MAC  = 10'b0000010000,
		ST_MUL  = 10'b0000100000,
		ST_AMUL = 10'b0001000000,
		ST_SCL  = 10'b0010000000,
		ST_WR   = 10'b0100000000,
		ST_DONE = 10'b1000000000
	} state_t;

	// configuration registers
	logic        lower_q, trans_q;
	logic [6:0]  size_n_q, depth_k_q;
	logic signed [31:0] alpha_q, beta_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= 1'b0;
			trans_q <= 1'b0;
			size_n_q <= 7'd64;
			depth_k_q <= 7'd64;
			alpha_q <= 32'sd65536;
			beta_q <= 32'sd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				syrk_pkg::REG_LOWER:     lower_q <= cfg_data[0];
				syrk_pkg::REG_TRANSPOSE: trans_q <= cfg_data[0];
				syrk_pkg::REG_SIZE_N:    size_n_q <= cfg_data[6:0];
				syrk_pkg::REG_DEPTH_K:   depth_k_q <= cfg_data[6:0];
				syrk_pkg::REG_ALPHA:     alpha_q <= cfg_data;
				syrk_pkg::REG_BETA:      beta_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// memories
	logic signed [31:0] a_mem [0:4095];
	logic signed [31:0] c_mem [0:4095];
	logic [11:0] a_raddr, c_raddr, a_waddr, c_waddr;
	logic        a_we, c_we;
	logic signed [31:0] a_wdata, c_wdata, a_rd_q, c_rd_q;

	always_ff @(posedge clk) begin
		if (a_we) a_mem[a_waddr] <= a_wdata;
		a_rd_q <= a_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (c_we) c_mem[c_waddr] <= c_wdata;
		c_rd_q <= c_mem[c_raddr];
	end

	state_t state_q;
	logic [6:0] n_eff, k_eff;
	logic [5:0] i_q, j_q, p_q;
	logic       last_p_q;
	logic signed [31:0] ai_q;
	logic signed [31:0] cold_q;
	logic signed [63:0] prod_s1;
	logic       prod_v_s1;
	logic signed [79:0] acc_q;
	logic [95:0] accm_q;
	logic [31:0] amag_q;
	logic        neg_q;
	logic [1:0]  limb_q;
	logic [111:0] scaled_q;
	logic signed [63:0] bterm_q;
	logic signed [31:0] aterm_q;
	logic       rd_pend_q;
	logic       out_valid_q;
	syrk_pkg::out_item_t out_q;

	assign n_eff = (size_n_q > 7'(LIM_N)) ? 7'(LIM_N) : size_n_q;
	assign k_eff = (depth_k_q > 7'(LIM_K)) ? 7'(LIM_K) : depth_k_q;

	// current entry lies in the selected triangle
	logic       in_tri;
	assign in_tri = lower_q ? (i_q >= j_q) : (i_q <= j_q);

	// op(A) addressing
	function automatic logic [11:0] op_addr(input logic t, input logic [5:0] r,
		input logic [5:0] p);
		op_addr = t ? {p, r} : {r, p};
	endfunction

	logic accept;
	assign in_ready = (state_q == ST_IDLE) && !rd_pend_q && (!out_valid_q || out_ready);
	assign accept = in_valid && in_ready;

	// saturation helper
	function automatic logic signed [31:0] sat(input logic signed [111:0] v);
		if (v > 112'(MAXP)) sat = 32'(MAXP);
		else if (v < 112'(MINN)) sat = 32'(MINN);
		else sat = v[31:0];
	endfunction

	// magnitude of the sum, multiplied by |alpha| one 32-bit limb per cycle
	logic [79:0]  acc_abs;
	logic [31:0]  limb_v;
	logic [63:0]  limb_p;
	logic [111:0] limb_sh;
	assign acc_abs = acc_q[79] ? 80'(-acc_q) : 80'(acc_q);
	always_comb begin
		case (limb_q)
			2'd0: limb_v = accm_q[31:0];
			2'd1: limb_v = accm_q[63:32];
			default: limb_v = accm_q[95:64];
		endcase
		limb_p = 64'(limb_v) * 64'(amag_q);
		case (limb_q)
			2'd0: limb_sh = 112'(limb_p);
			2'd1: limb_sh = 112'(limb_p) << 32;
			default: limb_sh = 112'(limb_p) << 64;
		endcase
	end

	// shift by 48 on the magnitude truncates toward zero, then restore the sign
	logic [111:0] amag_sh;
	logic signed [111:0] alpha_tz;
	assign amag_sh = scaled_q >> 48;
	assign alpha_tz = neg_q ? -$signed(amag_sh) : $signed(amag_sh);

	logic signed [63:0] bprod;
	logic signed [63:0] btz;
	assign bprod = cold_q * beta_q;
	assign btz = (bprod < 0) ? -((-bprod) >>> 16) : (bprod >>> 16);

	// final combine of the two registered terms
	logic signed [111:0] sum_v;
	logic signed [31:0] newc_d;
	assign sum_v = 112'(bterm_q) + 112'(aterm_q);
	assign newc_d = sat(sum_v);

	// read/write port muxes
	always_comb begin
		a_we = accept && (in_data.operation == syrk_pkg::OP_WRITE_A);
		a_waddr = {in_data.row_index, in_data.col_index};
		a_wdata = in_data.element_value;
		c_we = (accept && (in_data.operation == syrk_pkg::OP_WRITE_C)) || (state_q == ST_WR);
		c_waddr = (state_q == ST_WR) ? {i_q, j_q} : {in_data.row_index, in_data.col_index};
		c_wdata = (state_q == ST_WR) ? newc_d : in_data.element_value;
		c_raddr = (state_q == ST_IDLE) ? {in_data.row_index, in_data.col_index} : {i_q, j_q};
		a_raddr = (state_q == ST_RDJ) ? op_addr(trans_q, j_q, p_q) : op_addr(trans_q, i_q, p_q);
	end

	// run finished item goes out once the output slot is free
	logic out_set_done;
	assign out_set_done = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			j_q <= '0;
			p_q <= '0;
			last_p_q <= 1'b0;
			limb_q <= '0;
			prod_v_s1 <= 1'b0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= accept && (in_data.operation == syrk_pkg::OP_READ_C);
			prod_v_s1 <= (state_q == ST_MAC);
			out_valid_q <= rd_pend_q || out_set_done || (out_valid_q && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (accept && in_data.operation == syrk_pkg::OP_RUN) begin
						i_q <= '0;
						j_q <= '0;
						state_q <= (n_eff == 7'd0) ? ST_DONE : ST_RDC;
					end
				end
				ST_RDC: begin
					acc_q <= '0;
					p_q <= '0;
					last_p_q <= (k_eff <= 7'd1);
					// skip entries outside the triangle
					if (!in_tri) begin
						if (7'(j_q) + 7'd1 >= n_eff) begin
							j_q <= '0;
							i_q <= i_q + 6'd1;
							state_q <= (7'(i_q) + 7'd1 >= n_eff) ? ST_DONE : ST_RDC;
						end else j_q <= j_q + 6'd1;
					end else
						state_q <= (k_eff == 7'd0 || alpha_q == 0) ? ST_MUL : ST_RDI;
				end
				ST_RDI: begin
					if (p_q == 6'd0) cold_q <= c_rd_q;
					state_q <= ST_RDJ;
				end
				ST_RDJ: begin
					ai_q <= a_rd_q;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					prod_s1 <= ai_q * a_rd_q;
					if (last_p_q) state_q <= ST_MUL;
					else begin
						p_q <= p_q + 6'd1;
						last_p_q <= (7'(p_q) + 7'd2 >= k_eff);
						state_q <= ST_RDI;
					end
				end
				ST_MUL: begin
					if (k_eff == 7'd0 || alpha_q == 0) cold_q <= c_rd_q;
					// wait for the last product to reach the sum
					if (!prod_v_s1) begin
						accm_q <= 96'(acc_abs);
						amag_q <= alpha_q[31] ? 32'(-alpha_q) : 32'(alpha_q);
						neg_q <= acc_q[79] ^ alpha_q[31];
						scaled_q <= '0;
						limb_q <= '0;
						state_q <= ST_AMUL;
					end
				end
				ST_AMUL: begin
					scaled_q <= scaled_q + limb_sh;
					limb_q <= limb_q + 2'd1;
					if (limb_q == 2'd2) state_q <= ST_SCL;
				end
				ST_SCL: begin
					bterm_q <= (beta_q == 0) ? 64'sd0 : 64'(sat(112'(btz)));
					aterm_q <= sat(alpha_tz);
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (7'(j_q) + 7'd1 >= n_eff) begin
						j_q <= '0;
						i_q <= i_q + 6'd1;
						state_q <= (7'(i_q) + 7'd1 >= n_eff) ? ST_DONE : ST_RDC;
					end else begin
						j_q <= j_q + 6'd1;
						state_q <= ST_RDC;
					end
				end
				ST_DONE: begin
					if (out_set_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (prod_v_s1) acc_q <= acc_q + 80'(prod_s1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_q.result_kind <= syrk_pkg::KIND_READ;
			out_q.read_value <= c_rd_q;
		end else if (out_set_done) begin
			out_q.result_kind <= syrk_pkg::KIND_DONE;
			out_q.read_value <= 32'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== rtl/syrk_checker.sv =====
// ----------------------------------------------------------------------------
// syrk_checker
// port-level checks for the symmetric rank-k update core
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module syrk_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input syrk_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input syrk_pkg::out_item_t out_data
);
	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
	// run finished carries zero data
	`ASSERT_CLK(a_done_zero, clk, arst_n, out_valid && out_data.result_kind |-> out_data.read_value == 0, "done data nonzero")
	// an accepted read gives a read result after passing rd_pend_q and the output register
	`ASSERT_CLK(a_read_resp, clk, arst_n, in_valid && in_ready && in_data.operation == syrk_pkg::OP_READ_C |-> ##2 out_valid && !out_data.result_kind, "read lost")
endmodule

bind symmetric_rank_k_update_core syrk_checker u_chk (.*);

// ===== tb/tb_symmetric_rank_k_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_rank_k_update_core
// loads both stores, runs triangle updates under many register settings and
// checks every read and run-finished item against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_symmetric_rank_k_update_core;

	localparam int DIM = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	syrk_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	syrk_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	symmetric_rank_k_update_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// mirrored state of the block
	logic signed [31:0] a_mirror [DIM*DIM];
	logic signed [31:0] c_mirror [DIM*DIM];
	logic lower_q, trans_q;
	logic [6:0] n_q, k_q;
	logic signed [31:0] alpha_q, beta_q;

	syrk_pkg::out_item_t pending_results [$];
	int mismatches = 0;
	int checked = 0;
	int runs_done = 0;
	int reads_done = 0;
	int settings_used = 0;

	// signed saturation to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// arithmetic shift right with truncation toward zero
	function automatic logic signed [127:0] shift_trunc(input logic signed [127:0] v,
			input int sh);
		logic signed [127:0] mag;
		mag = (v < 0) ? -v : v;
		mag = mag >>> sh;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic logic signed [31:0] op_a_elem(input int i, input int p);
		return trans_q ? a_mirror[p*DIM+i] : a_mirror[i*DIM+p];
	endfunction

	// full triangle update on the mirror
	task automatic predict_triangle_update();
		int n, k;
		logic signed [127:0] acc, term, bterm, x, y;
		n = (n_q > 64) ? 64 : n_q;
		k = (k_q > 64) ? 64 : k_q;
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++) begin
				if (lower_q ? (i < j) : (i > j)) continue;
				bterm = 0;
				if (beta_q != 0) begin
					x = c_mirror[i*DIM+j];
					y = beta_q;
					bterm = sat32(shift_trunc(x * y, 16));
				end
				if (alpha_q != 0) begin
					acc = 0;
					for (int p = 0; p < k; p++) begin
						x = op_a_elem(i, p);
						y = op_a_elem(j, p);
						acc = acc + x * y;
					end
					y = alpha_q;
					term = sat32(shift_trunc(acc * y, 48));
					bterm = sat32(bterm + term);
				end
				c_mirror[i*DIM+j] = bterm[31:0];
			end
		end
	endtask

	// send one item, update the mirror at acceptance
	task automatic send_item(input syrk_pkg::op_t op, input int r, input int c,
			input logic [31:0] val);
		int gap;
		syrk_pkg::out_item_t res;
		gap = ($urandom_range(0, 99) < 70) ? 0 :
			($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data <= '{operation: op, row_index: r[5:0], col_index: c[5:0],
			element_value: val};
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		case (op)
			syrk_pkg::OP_WRITE_A: a_mirror[r*DIM+c] = val;
			syrk_pkg::OP_WRITE_C: c_mirror[r*DIM+c] = val;
			syrk_pkg::OP_RUN: begin
				predict_triangle_update();
				res.result_kind = syrk_pkg::KIND_DONE;
				res.read_value = '0;
				pending_results.push_back(res);
				runs_done++;
			end
			default: begin
				res.result_kind = syrk_pkg::KIND_READ;
				res.read_value = c_mirror[r*DIM+c];
				pending_results.push_back(res);
				reads_done++;
			end
		endcase
		@(negedge clk);
	endtask

	// let the block go idle: every result back plus a margin
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input syrk_pkg::reg_idx_t idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			syrk_pkg::REG_LOWER:     lower_q = val[0];
			syrk_pkg::REG_TRANSPOSE: trans_q = val[0];
			syrk_pkg::REG_SIZE_N:    n_q = val[6:0];
			syrk_pkg::REG_DEPTH_K:   k_q = val[6:0];
			syrk_pkg::REG_ALPHA:     alpha_q = val;
			syrk_pkg::REG_BETA:      beta_q = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(input logic lo, input logic tr, input int n, input int k,
			input logic [31:0] al, input logic [31:0] be);
		drain();
		write_reg(syrk_pkg::REG_LOWER, {31'd0, lo});
		write_reg(syrk_pkg::REG_TRANSPOSE, {31'd0, tr});
		write_reg(syrk_pkg::REG_SIZE_N, n);
		write_reg(syrk_pkg::REG_DEPTH_K, k);
		write_reg(syrk_pkg::REG_ALPHA, al);
		write_reg(syrk_pkg::REG_BETA, be);
		settings_used++;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 131072) - 65536;
			default: return $urandom;
		endcase
	endfunction

	// run then read three corners and one random spot of C
	task automatic run_and_sample();
		send_item(syrk_pkg::OP_RUN, 0, 0, $urandom);
		send_item(syrk_pkg::OP_READ_C, 0, 0, $urandom);
		send_item(syrk_pkg::OP_READ_C, 0, 63, $urandom);
		send_item(syrk_pkg::OP_READ_C, 63, 0, $urandom);
		send_item(syrk_pkg::OP_READ_C, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
	endtask

	// output side: random stalls, occasional long ones
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 20)
				stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	// result checker
	always @(posedge clk) begin
		syrk_pkg::out_item_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: kind %0d value %h", out_data.result_kind,
						out_data.read_value);
			end else begin
				exp_res = pending_results.pop_front();
				if (exp_res.result_kind !== out_data.result_kind ||
						exp_res.read_value !== out_data.read_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected kind %0d value %h, got kind %0d value %h",
							exp_res.result_kind, exp_res.read_value,
							out_data.result_kind, out_data.read_value);
				end
			end
		end
	end

	// clear all of C by two full-size runs with orders beyond the bound and no A terms
	task automatic test_full_clear();
		apply_setting(1'b0, 1'b0, 127, 0, 32'h00010000, 32'h0);
		send_item(syrk_pkg::OP_RUN, 0, 0, $urandom);
		apply_setting(1'b1, 1'b1, 100, 0, 32'h0, 32'h0);
		send_item(syrk_pkg::OP_RUN, 0, 0, $urandom);
		send_item(syrk_pkg::OP_READ_C, 0, 63, $urandom);
		send_item(syrk_pkg::OP_READ_C, 63, 0, $urandom);
		send_item(syrk_pkg::OP_READ_C, 63, 63, $urandom);
		send_item(syrk_pkg::OP_READ_C, 31, 32, $urandom);
		drain();
	endtask

	// fill the 8 by 8 corner of both stores and all of A row zero
	task automatic test_preload();
		for (int r = 0; r < 8; r++)
			for (int c = 0; c < 8; c++) begin
				send_item(syrk_pkg::OP_WRITE_A, r, c, rand_value());
				send_item(syrk_pkg::OP_WRITE_C, r, c, rand_value());
			end
		for (int c = 8; c < DIM; c++)
			send_item(syrk_pkg::OP_WRITE_A, 0, c, rand_value());
		drain();
	endtask

	// extremes and special cases of the update
	task automatic test_directed();
		send_item(syrk_pkg::OP_WRITE_A, 0, 0, 32'h80000000);
		send_item(syrk_pkg::OP_WRITE_A, 0, 1, 32'h80000000);
		send_item(syrk_pkg::OP_WRITE_C, 0, 0, 32'h7fffffff);
		send_item(syrk_pkg::OP_READ_C, 0, 0, $urandom);
		apply_setting(1'b0, 1'b0, 2, 2, 32'h7fffffff, 32'h7fffffff);
		run_and_sample();
		apply_setting(1'b1, 1'b1, 3, 8, 32'h80000000, 32'h80000000);
		run_and_sample();
		// depth beyond the bound walks the whole of A row zero
		apply_setting(1'b0, 1'b0, 1, 100, 32'h00010000, 32'h00010000);
		run_and_sample();
		// alpha and beta zero clear the triangle
		apply_setting(1'b0, 1'b1, 4, 0, 32'h0, 32'h0);
		run_and_sample();
		// alpha zero leaves only the beta scaling
		apply_setting(1'b1, 1'b0, 5, 3, 32'h0, 32'hffff0000);
		run_and_sample();
		// zero order still reports finished
		apply_setting(1'b0, 1'b0, 0, 5, 32'h00010000, 32'h00010000);
		run_and_sample();
		drain();
	endtask

	// random settings, each followed by a mix of writes, reads and runs
	task automatic test_random();
		int n, k;
		logic [31:0] al, be;
		for (int ph = 0; ph < 9; ph++) begin
			n = ($urandom_range(0, 9) == 0) ? 64 : $urandom_range(0, 8);
			k = (n == 64) ? 0 : $urandom_range(0, 8);
			al = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_value();
			be = ($urandom_range(0, 4) == 0) ? 32'h0 : rand_value();
			apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n, k, al, be);
			for (int it = 0; it < 30; it++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4:
						send_item(syrk_pkg::OP_WRITE_A, $urandom_range(0, 63),
							$urandom_range(0, 63), rand_value());
					5, 6, 7, 8, 9:
						send_item(syrk_pkg::OP_WRITE_C, $urandom_range(0, 63),
							$urandom_range(0, 63), rand_value());
					10, 11:
						send_item(syrk_pkg::OP_RUN, $urandom_range(0, 63),
							$urandom_range(0, 63), $urandom);
					default:
						send_item(syrk_pkg::OP_READ_C, $urandom_range(0, 63) & (ph[0] ? 63 : 7),
							$urandom_range(0, 63) & (ph[0] ? 63 : 7), $urandom);
				endcase
			end
		end
		drain();
	endtask

	initial begin
		lower_q = 1'b0;
		trans_q = 1'b0;
		n_q = 7'd64;
		k_q = 7'd64;
		alpha_q = 32'sd65536;
		beta_q = 32'sd0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_full_clear();
		test_preload();
		test_directed();
		test_random();
		$display("covered %0d runs and %0d reads over %0d register settings",
			runs_done, reads_done, settings_used);
		$display("checked %0d output items, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog
	initial begin
		#100ms;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== symmetric_rank_k_update_core.f =====
+incdir+rtl
rtl/syrk_pkg.sv
rtl/symmetric_rank_k_update_core.sv
rtl/syrk_checker.sv
tb/tb_symmetric_rank_k_update_core.sv
